FILE: rtl/sobf_pkg.sv
// ----------------------------------------------------------------------------
// sobf_pkg
// Shared constants and register codes of the oriented box beam filter.
// ----------------------------------------------------------------------------
package sobf_pkg;

  // Rotation factors: signed Q1.14
  localparam int ROT_WIDTH = 16;
  localparam int ROT_FRAC  = 14;
  localparam logic [ROT_WIDTH-1:0] ROT_COS_RESET = 16'd16384;

  // Configuration port
  localparam int APB_DATA_WIDTH = 32;
  localparam int APB_ADDR_WIDTH = 5;

  // Register codes, byte address is 4 * code
  typedef enum logic [2:0] {
    REG_CENTER_X    = 3'd0,
    REG_CENTER_Y    = 3'd1,
    REG_ROT_COS     = 3'd2,
    REG_ROT_SIN     = 3'd3,
    REG_HALF_LENGTH = 3'd4,
    REG_HALF_DEPTH  = 3'd5,
    REG_Z_LOW       = 3'd6,
    REG_Z_HIGH      = 3'd7
  } cfg_reg_t;

endpackage

FILE: rtl/sobf_delay.sv
// ----------------------------------------------------------------------------
// sobf_delay
// Fixed-length payload delay line that advances with the pipeline enable.
// ----------------------------------------------------------------------------
module sobf_delay #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1
) (
  input  logic             clk,
  input  logic             en,
  input  logic [WIDTH-1:0] d,
  output logic [WIDTH-1:0] q
);

  logic [WIDTH-1:0] line [DEPTH];

  // Shift the payload one stage per advance
  always_ff @(posedge clk) begin
    if (en) begin
      line[0] <= d;
      for (int i = 1; i < DEPTH; i++) begin
        line[i] <= line[i-1];
      end
    end
  end

  assign q = line[DEPTH-1];

endmodule

FILE: rtl/sobf_mul.sv
// ----------------------------------------------------------------------------
// sobf_mul
// Signed multiplier split into four partial products over three stages.
// ----------------------------------------------------------------------------
module sobf_mul #(
  parameter int WA = 40,
  parameter int WB = 40
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [WA-1:0]    a,
  input  logic signed [WB-1:0]    b,
  output logic signed [WA+WB-1:0] p
);

  localparam int KA = WA / 2;
  localparam int KB = WB / 2;
  localparam int HA = WA - KA;
  localparam int HB = WB - KB;
  localparam int WP = WA + WB;

  logic signed [HA-1:0]      a_hi;
  logic        [KA-1:0]      a_lo;
  logic signed [HB-1:0]      b_hi;
  logic        [KB-1:0]      b_lo;
  logic signed [HA+HB-1:0]   pp_hh;
  logic signed [HA+KB:0]     pp_hl;
  logic signed [KA+HB:0]     pp_lh;
  logic        [KA+KB-1:0]   pp_ll;
  logic signed [WP-1:0]      sum_a;
  logic signed [WP-1:0]      sum_b;

  assign a_hi = a[WA-1:KA];
  assign a_lo = a[KA-1:0];
  assign b_hi = b[WB-1:KB];
  assign b_lo = b[KB-1:0];

  // Form partial products, pair them up, then add the pairs
  always_ff @(posedge clk) begin
    if (en) begin
      pp_hh <= a_hi * b_hi;
      pp_hl <= a_hi * $signed({1'b0, b_lo});
      pp_lh <= $signed({1'b0, a_lo}) * b_hi;
      pp_ll <= a_lo * b_lo;
      sum_a <= (WP'(pp_hh) <<< (KA + KB)) + $signed(WP'(pp_ll));
      sum_b <= (WP'(pp_hl) <<< KA) + (WP'(pp_lh) <<< KB);
      p     <= sum_a + sum_b;
    end
  end

endmodule

FILE: rtl/sobf_cross.sv
// ----------------------------------------------------------------------------
// sobf_cross
// Edge-cross separating axis test: |a1*b1 - a2*b2| <= c1*e1 + c2*e2.
// ----------------------------------------------------------------------------
module sobf_cross #(
  parameter int MW = 40
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [MW-1:0] a1,
  input  logic signed [MW-1:0] b1,
  input  logic signed [MW-1:0] a2,
  input  logic signed [MW-1:0] b2,
  input  logic signed [MW-1:0] c1,
  input  logic signed [MW-1:0] e1,
  input  logic signed [MW-1:0] c2,
  input  logic signed [MW-1:0] e2,
  output logic                 ok
);

  localparam int PW = 2 * MW;
  localparam int DW = PW + 1;

  logic signed [PW-1:0] p1, p2, q1, q2;
  logic signed [DW-1:0] diff, rsum, mag, rsum_d;

  sobf_mul #(.WA(MW), .WB(MW)) u_mul_p1 (.clk(clk), .en(en), .a(a1), .b(b1), .p(p1));
  sobf_mul #(.WA(MW), .WB(MW)) u_mul_p2 (.clk(clk), .en(en), .a(a2), .b(b2), .p(p2));
  sobf_mul #(.WA(MW), .WB(MW)) u_mul_q1 (.clk(clk), .en(en), .a(c1), .b(e1), .p(q1));
  sobf_mul #(.WA(MW), .WB(MW)) u_mul_q2 (.clk(clk), .en(en), .a(c2), .b(e2), .p(q2));

  // Combine, take magnitude, compare against the box radius
  always_ff @(posedge clk) begin
    if (en) begin
      diff   <= DW'(p1) - DW'(p2);
      rsum   <= DW'(q1) + DW'(q2);
      mag    <= diff[DW-1] ? -diff : diff;
      rsum_d <= rsum;
      ok     <= mag <= rsum_d;
    end
  end

endmodule

FILE: rtl/sobf_xform.sv
// ----------------------------------------------------------------------------
// sobf_xform
// Move both beam points into the box frame, form doubled midpoint and
// direction per axis, and run the three face tests.
// ----------------------------------------------------------------------------
module sobf_xform #(
  parameter int W  = 20,
  parameter int MW = 40
) (
  input  logic                                clk,
  input  logic                                en,
  input  logic signed [W-1:0]                 center_x,
  input  logic signed [W-1:0]                 center_y,
  input  logic signed [sobf_pkg::ROT_WIDTH-1:0] rot_cos,
  input  logic signed [sobf_pkg::ROT_WIDTH-1:0] rot_sin,
  input  logic        [W-2:0]                 half_length,
  input  logic        [W-2:0]                 half_depth,
  input  logic signed [W-1:0]                 z_low,
  input  logic signed [W-1:0]                 z_high,
  input  logic signed [W-1:0]                 origin_x,
  input  logic signed [W-1:0]                 origin_y,
  input  logic signed [W-1:0]                 origin_z,
  input  logic signed [W-1:0]                 end_x,
  input  logic signed [W-1:0]                 end_y,
  input  logic signed [W-1:0]                 end_z,
  output logic signed [MW-1:0]                mx,
  output logic signed [MW-1:0]                my,
  output logic signed [MW-1:0]                mz,
  output logic signed [MW-1:0]                dx,
  output logic signed [MW-1:0]                dy,
  output logic signed [MW-1:0]                dz,
  output logic signed [MW-1:0]                adx,
  output logic signed [MW-1:0]                ady,
  output logic signed [MW-1:0]                adz,
  output logic signed [MW-1:0]                h2x,
  output logic signed [MW-1:0]                h2y,
  output logic signed [MW-1:0]                h2z,
  output logic                                face_ok
);

  import sobf_pkg::*;

  localparam int DW  = W + 1;
  localparam int ZW  = W + 2;
  localparam int PW1 = W + ROT_WIDTH + 1;
  localparam int LW  = PW1 + 1;
  localparam int VW  = LW + 1;

  // Stage 1: offsets from the centre, z terms
  logic signed [DW-1:0]  dox, doy, dex, dey, zd1, hz1;
  logic signed [ZW-1:0]  zm1;
  logic                  zbad1;
  // Stage 2: rotation products
  logic signed [PW1-1:0] p_ox_c, p_oy_s, p_ox_s, p_oy_c;
  logic signed [PW1-1:0] p_ex_c, p_ey_s, p_ex_s, p_ey_c;
  logic signed [DW-1:0]  zd2, hz2;
  logic signed [ZW-1:0]  zm2;
  logic                  zbad2;
  // Stage 3: local coordinates
  logic signed [LW-1:0]  olx, oly, elx, ely;
  logic signed [DW-1:0]  zd3, hz3;
  logic signed [ZW-1:0]  zm3;
  logic                  zbad3;
  // Stage 4: doubled midpoint and direction
  logic signed [VW-1:0]  mx4, my4, dx4, dy4;
  logic signed [DW-1:0]  zd4, hz4;
  logic signed [ZW-1:0]  zm4;
  logic                  zbad4;
  // Stage 5: magnitudes
  logic signed [MW-1:0]  amx, amy, amz;
  logic                  zbad5;

  always_ff @(posedge clk) begin
    if (en) begin
      // stage 1
      dox   <= DW'(origin_x) - DW'(center_x);
      doy   <= DW'(origin_y) - DW'(center_y);
      dex   <= DW'(end_x) - DW'(center_x);
      dey   <= DW'(end_y) - DW'(center_y);
      zm1   <= ZW'(origin_z) + ZW'(end_z) - ZW'(z_low) - ZW'(z_high);
      zd1   <= DW'(end_z) - DW'(origin_z);
      hz1   <= DW'(z_high) - DW'(z_low);
      zbad1 <= z_low > z_high;
      // stage 2
      p_ox_c <= dox * rot_cos;
      p_oy_s <= doy * rot_sin;
      p_ox_s <= dox * rot_sin;
      p_oy_c <= doy * rot_cos;
      p_ex_c <= dex * rot_cos;
      p_ey_s <= dey * rot_sin;
      p_ex_s <= dex * rot_sin;
      p_ey_c <= dey * rot_cos;
      zm2    <= zm1;
      zd2    <= zd1;
      hz2    <= hz1;
      zbad2  <= zbad1;
      // stage 3
      olx   <= LW'(p_ox_c) - LW'(p_oy_s);
      oly   <= LW'(p_ox_s) + LW'(p_oy_c);
      elx   <= LW'(p_ex_c) - LW'(p_ey_s);
      ely   <= LW'(p_ex_s) + LW'(p_ey_c);
      zm3   <= zm2;
      zd3   <= zd2;
      hz3   <= hz2;
      zbad3 <= zbad2;
      // stage 4
      mx4   <= VW'(olx) + VW'(elx);
      dx4   <= VW'(elx) - VW'(olx);
      my4   <= VW'(oly) + VW'(ely);
      dy4   <= VW'(ely) - VW'(oly);
      zm4   <= zm3;
      zd4   <= zd3;
      hz4   <= hz3;
      zbad4 <= zbad3;
      // stage 5
      mx    <= MW'(mx4);
      my    <= MW'(my4);
      mz    <= MW'(zm4);
      dx    <= MW'(dx4);
      dy    <= MW'(dy4);
      dz    <= MW'(zd4);
      amx   <= mx4[VW-1] ? -MW'(mx4) : MW'(mx4);
      amy   <= my4[VW-1] ? -MW'(my4) : MW'(my4);
      amz   <= zm4[ZW-1] ? -MW'(zm4) : MW'(zm4);
      adx   <= dx4[VW-1] ? -MW'(dx4) : MW'(dx4);
      ady   <= dy4[VW-1] ? -MW'(dy4) : MW'(dy4);
      adz   <= zd4[DW-1] ? -MW'(zd4) : MW'(zd4);
      h2x   <= $signed(MW'({half_length, {(ROT_FRAC + 1){1'b0}}}));
      h2y   <= $signed(MW'({half_depth, {(ROT_FRAC + 1){1'b0}}}));
      h2z   <= MW'(hz4);
      zbad5 <= zbad4;
      // stage 6: face tests, empty z slab rules the beam out
      face_ok <= !zbad5 && (amx <= h2x + adx) && (amy <= h2y + ady)
                 && (amz <= h2z + adz);
    end
  end

endmodule

FILE: rtl/segment_oriented_box_filter_core.sv
// ----------------------------------------------------------------------------
// segment_oriented_box_filter_core
// Oriented box crossing test for lidar beams, with APB register access.
// ----------------------------------------------------------------------------
// Throughput: one beam per cycle while the output is not stalled; the rotation
//   products and the split wide multipliers of the edge-cross tests are fully pipelined.
// A stall at the output holds every stage through one shared enable.
// Reset clears the stage valid bits and the configuration registers;
//   rot_cos resets to 1.0.
module segment_oriented_box_filter_core #(
  parameter int COORD_WIDTH = 20
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // origin_x, origin_y, origin_z, end_x, end_y, end_z (lowest first)
  input  logic [((6*COORD_WIDTH+7)/8)*8-1:0]    s_tdata,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  // crosses, out_x, out_y, out_z (lowest first)
  output logic [((3*COORD_WIDTH+8)/8)*8-1:0]    m_tdata,
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [sobf_pkg::APB_ADDR_WIDTH-1:0]   paddr,
  input  logic [sobf_pkg::APB_DATA_WIDTH-1:0]   pwdata,
  output logic [sobf_pkg::APB_DATA_WIDTH-1:0]   prdata,
  output logic                                  pready
);

  import sobf_pkg::*;

  localparam int W      = COORD_WIDTH;
  localparam int MW     = W + 20;
  localparam int MTW    = ((3*W+8)/8)*8;
  localparam int DEPTH  = 12;
  localparam int FACE_D = 5;

  // Configuration registers
  logic [W-1:0]         center_x, center_y, z_low, z_high;
  logic [ROT_WIDTH-1:0] rot_cos, rot_sin;
  logic [W-2:0]         half_length, half_depth;

  logic                 adv;
  logic [DEPTH-1:0]     vld;
  logic signed [MW-1:0] mx, my, mz, dx, dy, dz, adx, ady, adz, h2x, h2y, h2z;
  logic                 face_ok, face_d, ok_x, ok_y, ok_z, crosses;
  logic [3*W-1:0]       end_d;

  // Register write on the access phase
  always_ff @(posedge clk) begin
    if (rst) begin
      center_x    <= '0;
      center_y    <= '0;
      rot_cos     <= ROT_COS_RESET;
      rot_sin     <= '0;
      half_length <= '0;
      half_depth  <= '0;
      z_low       <= '0;
      z_high      <= '0;
    end else if (psel && penable && pwrite && pready) begin
      case (cfg_reg_t'(paddr[4:2]))
        REG_CENTER_X:    center_x    <= pwdata[W-1:0];
        REG_CENTER_Y:    center_y    <= pwdata[W-1:0];
        REG_ROT_COS:     rot_cos     <= pwdata[ROT_WIDTH-1:0];
        REG_ROT_SIN:     rot_sin     <= pwdata[ROT_WIDTH-1:0];
        REG_HALF_LENGTH: half_length <= pwdata[W-2:0];
        REG_HALF_DEPTH:  half_depth  <= pwdata[W-2:0];
        REG_Z_LOW:       z_low       <= pwdata[W-1:0];
        REG_Z_HIGH:      z_high      <= pwdata[W-1:0];
        default: ;
      endcase
    end
  end

  // Register read
  always_comb begin
    case (cfg_reg_t'(paddr[4:2]))
      REG_CENTER_X:    prdata = APB_DATA_WIDTH'(center_x);
      REG_CENTER_Y:    prdata = APB_DATA_WIDTH'(center_y);
      REG_ROT_COS:     prdata = APB_DATA_WIDTH'(rot_cos);
      REG_ROT_SIN:     prdata = APB_DATA_WIDTH'(rot_sin);
      REG_HALF_LENGTH: prdata = APB_DATA_WIDTH'(half_length);
      REG_HALF_DEPTH:  prdata = APB_DATA_WIDTH'(half_depth);
      REG_Z_LOW:       prdata = APB_DATA_WIDTH'(z_low);
      REG_Z_HIGH:      prdata = APB_DATA_WIDTH'(z_high);
      default:         prdata = '0;
    endcase
  end

  assign pready = 1'b1;

  // Advance the whole pipeline unless a finished result waits
  assign adv      = !vld[DEPTH-1] || m_tready;
  assign s_tready = adv;
  assign m_tvalid = vld[DEPTH-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[DEPTH-2:0], s_tvalid};
    end
  end

  sobf_xform #(.W(W), .MW(MW)) u_xform (
    .clk         (clk),
    .en          (adv),
    .center_x    ($signed(center_x)),
    .center_y    ($signed(center_y)),
    .rot_cos     ($signed(rot_cos)),
    .rot_sin     ($signed(rot_sin)),
    .half_length (half_length),
    .half_depth  (half_depth),
    .z_low       ($signed(z_low)),
    .z_high      ($signed(z_high)),
    .origin_x    ($signed(s_tdata[0*W +: W])),
    .origin_y    ($signed(s_tdata[1*W +: W])),
    .origin_z    ($signed(s_tdata[2*W +: W])),
    .end_x       ($signed(s_tdata[3*W +: W])),
    .end_y       ($signed(s_tdata[4*W +: W])),
    .end_z       ($signed(s_tdata[5*W +: W])),
    .mx          (mx),
    .my          (my),
    .mz          (mz),
    .dx          (dx),
    .dy          (dy),
    .dz          (dz),
    .adx         (adx),
    .ady         (ady),
    .adz         (adz),
    .h2x         (h2x),
    .h2y         (h2y),
    .h2z         (h2z),
    .face_ok     (face_ok)
  );

  // Edge-cross axes: direction crossed with each box edge
  sobf_cross #(.MW(MW)) u_cross_x (
    .clk(clk), .en(adv), .a1(my), .b1(dz), .a2(mz), .b2(dy),
    .c1(h2y), .e1(adz), .c2(h2z), .e2(ady), .ok(ok_x)
  );
  sobf_cross #(.MW(MW)) u_cross_y (
    .clk(clk), .en(adv), .a1(mz), .b1(dx), .a2(mx), .b2(dz),
    .c1(h2x), .e1(adz), .c2(h2z), .e2(adx), .ok(ok_y)
  );
  sobf_cross #(.MW(MW)) u_cross_z (
    .clk(clk), .en(adv), .a1(mx), .b1(dy), .a2(my), .b2(dx),
    .c1(h2x), .e1(ady), .c2(h2y), .e2(adx), .ok(ok_z)
  );

  // Align the face result with the cross results
  sobf_delay #(.WIDTH(1), .DEPTH(FACE_D)) u_face_dly (
    .clk(clk), .en(adv), .d(face_ok), .q(face_d)
  );

  // Carry the return point alongside
  sobf_delay #(.WIDTH(3*W), .DEPTH(DEPTH)) u_end_dly (
    .clk(clk), .en(adv), .d(s_tdata[3*W +: 3*W]), .q(end_d)
  );

  // Final verdict: no separating axis found
  always_ff @(posedge clk) begin
    if (adv) begin
      crosses <= face_d && ok_x && ok_y && ok_z;
    end
  end

  assign m_tdata = MTW'({end_d, crosses});

  // An empty z slab never yields a crossing
  a_empty_slab: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && ($signed(z_low) > $signed(z_high)) |-> !m_tdata[0])
    else $error("crossing reported with inverted z bounds");

  // A waiting result stalls the input side
  a_stall_input: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |-> !s_tready)
    else $error("input taken while result stalled");

  // Nothing leaves the pipeline right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result request right after reset");

endmodule

FILE: test/segment_oriented_box_filter_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_oriented_box_filter_core_test
// Streams lidar beams through the oriented box filter and compares every
// result with an in-bench slab test. The box is moved, rotated and resized
// over the APB port between phases; both stream sides idle and stall.
// ----------------------------------------------------------------------------
module segment_oriented_box_filter_core_test;
  import sobf_pkg::*;

  localparam int CW      = 20;
  localparam int S_WIDTH = ((6*CW+7)/8)*8;
  localparam int M_WIDTH = ((3*CW+8)/8)*8;
  localparam int LATENCY = 12;

  typedef struct {
    logic signed [CW-1:0] ox, oy, oz, ex, ey, ez;
  } beam_t;

  typedef struct {
    logic          crosses;
    logic [CW-1:0] x, y, z;
  } hit_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic [S_WIDTH-1:0] s_tdata = '0;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  logic [M_WIDTH-1:0] m_tdata;
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [APB_ADDR_WIDTH-1:0] paddr = '0;
  logic [APB_DATA_WIDTH-1:0] pwdata = '0;
  logic [APB_DATA_WIDTH-1:0] prdata;
  logic               pready;

  // Shadow of the box registers
  logic signed [CW-1:0]        box_cx = '0, box_cy = '0, box_zl = '0, box_zh = '0;
  logic signed [ROT_WIDTH-1:0] box_cos = ROT_COS_RESET, box_sin = '0;
  logic [CW-2:0]               box_hl = '0, box_hd = '0;

  hit_t hit_queue[$];
  int   mismatches = 0;
  int   send_idle = 0;
  int   recv_idle = 0;
  int   hold_left = 0;

  segment_oriented_box_filter_core #(.COORD_WIDTH(CW)) u_top (
    .clk(clk), .rst(rst),
    .s_tdata(s_tdata), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tdata(m_tdata), .m_tvalid(m_tvalid), .m_tready(m_tready),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #10 clk = ~clk;

  // Sign of an/ad - bn/bd, denominators positive
  function automatic int frac_cmp(longint an, longint ad, longint bn, longint bd);
    logic signed [127:0] a1, a2, b1, b2, p, q;
    a1 = an; a2 = ad; b1 = bn; b2 = bd;
    p = a1 * b2;
    q = b1 * a2;
    return (p > q) ? 1 : ((p < q) ? -1 : 0);
  endfunction

  // Narrow the entry and exit parameters by one slab
  function automatic bit slab_pass(longint o, longint e, longint lo, longint hi,
                                   inout longint nn, inout longint nd,
                                   inout longint fn, inout longint fd);
    longint dir, in_n, out_n, den;
    dir = e - o;
    if (dir == 0) return (o >= lo) && (o <= hi);
    if (dir > 0) begin
      in_n = lo - o; out_n = hi - o; den = dir;
    end else begin
      in_n = o - hi; out_n = o - lo; den = -dir;
    end
    if (frac_cmp(in_n, den, nn, nd) > 0) begin
      nn = in_n; nd = den;
    end
    if (frac_cmp(out_n, den, fn, fd) < 0) begin
      fn = out_n; fd = den;
    end
    return 1'b1;
  endfunction

  function automatic bit beam_crosses(beam_t b);
    longint c, s, hl, hd, oxr, oyr, exr, eyr, nn, nd, fn, fd;
    bit pass;
    c = box_cos; s = box_sin;
    hl = longint'(box_hl) * 16384;
    hd = longint'(box_hd) * 16384;
    oxr = longint'(b.ox) - box_cx; oyr = longint'(b.oy) - box_cy;
    exr = longint'(b.ex) - box_cx; eyr = longint'(b.ey) - box_cy;
    nn = 0; nd = 1; fn = 1; fd = 1;
    pass = slab_pass(oxr*c - oyr*s, exr*c - eyr*s, -hl, hl, nn, nd, fn, fd);
    if (pass) pass = slab_pass(oxr*s + oyr*c, exr*s + eyr*c, -hd, hd, nn, nd, fn, fd);
    if (pass) pass = slab_pass(b.oz, b.ez, box_zl, box_zh, nn, nd, fn, fd);
    return pass && (frac_cmp(nn, nd, fn, fd) <= 0);
  endfunction

  task automatic report_mismatch(string field, longint want, longint got);
    $display("mismatch %s: expected %0d, got %0d at %0t", field, want, got, $realtime);
    mismatches++;
  endtask

  // Check every result request against the oldest expectation
  always @(posedge clk) begin
    hit_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (hit_queue.size() == 0) begin
        report_mismatch("unexpected result", 0, 1);
      end else begin
        want = hit_queue.pop_front();
        if (m_tdata[0] !== want.crosses) report_mismatch("crosses", want.crosses, m_tdata[0]);
        if (m_tdata[CW:1] !== want.x) report_mismatch("out_x", want.x, m_tdata[CW:1]);
        if (m_tdata[2*CW:CW+1] !== want.y) report_mismatch("out_y", want.y, m_tdata[2*CW:CW+1]);
        if (m_tdata[3*CW:2*CW+1] !== want.z)
          report_mismatch("out_z", want.z, m_tdata[3*CW:2*CW+1]);
      end
    end
  end

  // Drive the receiver: long hold-offs first, else random stalls
  always @(negedge clk) begin
    if (hold_left > 0) begin
      m_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= recv_idle);
    end
  end

  // Send one beam request and record its expected result on acceptance
  task automatic send_beam(beam_t b);
    hit_t want;
    while ($urandom_range(0, 99) < send_idle) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tdata = {b.ez, b.ey, b.ex, b.oz, b.oy, b.ox};
    s_tvalid = 1'b1;
    do @(posedge clk); while (!s_tready);
    want.crosses = beam_crosses(b);
    want.x = b.ex; want.y = b.ey; want.z = b.ez;
    hit_queue.insert(hit_queue.size(), want);
    @(negedge clk);
    s_tvalid = 1'b0;
  endtask

  task automatic wait_drained();
    while (hit_queue.size() != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  task automatic write_reg(cfg_reg_t r, longint v);
    psel = 1'b1; pwrite = 1'b1; penable = 1'b0;
    paddr = APB_ADDR_WIDTH'(r) << 2;
    pwdata = APB_DATA_WIDTH'(v);
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    case (r)
      REG_CENTER_X:    box_cx  = CW'(v);
      REG_CENTER_Y:    box_cy  = CW'(v);
      REG_ROT_COS:     box_cos = ROT_WIDTH'(v);
      REG_ROT_SIN:     box_sin = ROT_WIDTH'(v);
      REG_HALF_LENGTH: box_hl  = (CW-1)'(v);
      REG_HALF_DEPTH:  box_hd  = (CW-1)'(v);
      REG_Z_LOW:       box_zl  = CW'(v);
      REG_Z_HIGH:      box_zh  = CW'(v);
      default: ;
    endcase
  endtask

  task automatic set_box(longint cx, longint cy, longint c, longint s,
                         longint hl, longint hd, longint zl, longint zh);
    wait_drained();
    write_reg(REG_CENTER_X, cx);
    write_reg(REG_CENTER_Y, cy);
    write_reg(REG_ROT_COS, c);
    write_reg(REG_ROT_SIN, s);
    write_reg(REG_HALF_LENGTH, hl);
    write_reg(REG_HALF_DEPTH, hd);
    write_reg(REG_Z_LOW, zl);
    write_reg(REG_Z_HIGH, zh);
  endtask

  function automatic beam_t mk(longint ox, longint oy, longint oz,
                               longint ex, longint ey, longint ez);
    beam_t b;
    b.ox = ox; b.oy = oy; b.oz = oz; b.ex = ex; b.ey = ey; b.ez = ez;
    return b;
  endfunction

  function automatic longint clip(longint v);
    if (v > 524287) return 524287;
    if (v < -524288) return -524288;
    return v;
  endfunction

  function automatic longint near(longint mid, longint span);
    return clip(mid + longint'($urandom_range(0, 32'(2*span))) - span);
  endfunction

  function automatic longint any_coord();
    return longint'(signed'(CW'($urandom)));
  endfunction

  // Mostly beams aimed around the box, some anywhere
  function automatic beam_t random_beam();
    beam_t b;
    longint span;
    span = 2 * (longint'(box_hl) + longint'(box_hd)) + 4096;
    if (span > 300000) span = 300000;
    if ($urandom_range(0, 9) < 2) begin
      b = mk(any_coord(), any_coord(), any_coord(), any_coord(), any_coord(), any_coord());
    end else begin
      b = mk(near(box_cx, 2*span), near(box_cy, 2*span), near(box_zl, span),
             near(box_cx, span), near(box_cy, span), near(box_zh, span));
    end
    if ($urandom_range(0, 7) == 0) b.ex = b.ox;
    if ($urandom_range(0, 7) == 0) b.ey = b.oy;
    if ($urandom_range(0, 7) == 0) b.ez = b.oz;
    return b;
  endfunction

  task automatic random_box();
    longint cx, cy, c, s, hl, hd, zl, zh, t;
    if ($urandom_range(0, 3) == 0) begin
      cx = any_coord(); cy = any_coord();
    end else begin
      cx = near(0, 60000); cy = near(0, 60000);
    end
    if ($urandom_range(0, 4) == 0) begin
      c = longint'(signed'(16'($urandom))); s = longint'(signed'(16'($urandom)));
    end else begin
      c = longint'($urandom_range(0, 32768)) - 16384;
      s = $rtoi($sqrt(16384.0 * 16384.0 - real'(c * c)));
      if ($urandom_range(0, 1)) s = -s;
    end
    if ($urandom_range(0, 9) == 0) begin
      hl = $urandom_range(0, 524287); hd = $urandom_range(0, 524287);
    end else begin
      hl = $urandom_range(0, 20000); hd = $urandom_range(0, 20000);
    end
    zl = near(0, 20000); zh = near(0, 20000);
    if (zl > zh && $urandom_range(0, 4) != 0) begin
      t = zl; zl = zh; zh = t;
    end
    set_box(cx, cy, c, s, hl, hd, zl, zh);
  endtask

  // Reset state: a box of zero size at the origin, identity rotation
  task automatic test_reset_box();
    send_beam(mk(-1000, 0, 0, 1000, 0, 0));
    send_beam(mk(-1000, 1, 0, 1000, 1, 0));
    send_beam(mk(0, -500, -500, 0, 500, 500));
  endtask

  task automatic test_directed();
    set_box(0, 0, 16384, 0, 1024, 2048, -1024, 1024);
    send_beam(mk(-5000, 0, 0, 5000, 0, 0));            // straight through
    send_beam(mk(-5000, 3000, 0, 5000, 3000, 0));      // passes beside
    send_beam(mk(-5000, 0, 0, -1024, 0, 0));           // ends on a face
    send_beam(mk(-5000, 0, 0, -1025, 0, 0));           // stops just short
    send_beam(mk(0, 0, 0, 10, 10, 10));                // wholly inside
    send_beam(mk(500, 2048, 0, 600, 2048, 5));         // zero y direction on the bound
    send_beam(mk(500, 2049, 0, 600, 2049, 5));         // zero y direction outside
    send_beam(mk(-524288, -524288, -524288, 524287, 524287, 524287));
    send_beam(mk(524287, 524287, 524287, -524288, -524288, -524288));
    send_beam(mk(524287, -524288, 0, 524287, -524288, 0));
    // Inverted z bounds: empty slab
    set_box(0, 0, 16384, 0, 1024, 2048, 1024, -1024);
    send_beam(mk(-5000, 0, 0, 5000, 0, 0));
    send_beam(mk(0, 0, -5000, 0, 0, 5000));
    // Rotation factors out of range, extreme center and half sizes
    set_box(524287, -524288, -32768, 32767, 524287, 0, -524288, 524287);
    send_beam(mk(524287, -524288, 0, 524287, -524288, 0));
    send_beam(mk(-524288, 524287, -524288, 524287, -524288, 524287));
    send_beam(mk(500000, -500000, 10, 524287, -524288, -10));
    set_box(-524288, 524287, 0, -16384, 0, 524287, 0, 0);
    send_beam(mk(-524288, 524287, 0, -524288, 524287, 0));
    send_beam(mk(-524288, 0, -100, -524288, 524287, 100));
    send_beam(mk(-524288, -524288, 0, 524287, 524287, 0));
  endtask

  task automatic test_random(int items);
    for (int i = 0; i < items; i++) begin
      if (i % 110 == 0) random_box();
      send_beam(random_beam());
    end
  endtask

  // Fill the pipeline against a stalled receiver, pause until empty, then send more beams
  task automatic test_backpressure();
    random_box();
    send_idle = 0;
    hold_left = 300;
    for (int i = 0; i < 60; i++) send_beam(random_beam());
    wait_drained();
    for (int i = 0; i < 20; i++) send_beam(random_beam());
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_reset_box();
    test_directed();
    send_idle = 21; recv_idle = 88;
    test_random(330);
    send_idle = 88; recv_idle = 21;
    test_random(330);
    send_idle = 0; recv_idle = 0;
    test_random(330);
    test_backpressure();
    wait_drained();
    repeat (LATENCY * 2) @(negedge clk);
    if (mismatches == 0 && hit_queue.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
